FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. They expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ils_pkg.sv
package ils_pkg;

    localparam int IDX_W = 5;
    localparam int LEN_W = 5;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        ACT_APPEND       = 3'd0,
        ACT_INSERT       = 3'd1,
        ACT_REMOVE_AT    = 3'd2,
        ACT_REMOVE_FIRST = 3'd3,
        ACT_REMOVE_LAST  = 3'd4,
        ACT_READ         = 3'd5
    } t_action;

    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          index;
        logic signed [VAL_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic                      ok;
        logic [LEN_W-1:0]          length;
        logic signed [VAL_W-1:0]   read_value;
    } t_result;

    // Shift request broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_op;

endpackage

FILE: src/ils_cell.sv
module ils_cell #(
    parameter int AW = 4,
    parameter int K  = 0
) (
    input  logic                              i_clk,
    input  ils_pkg::t_cell_op                 i_op,
    input  logic [AW-1:0]                     i_pos,
    input  logic signed [ils_pkg::VAL_W-1:0]  i_value,
    input  logic signed [ils_pkg::VAL_W-1:0]  i_left,
    input  logic signed [ils_pkg::VAL_W-1:0]  i_right,
    output logic signed [ils_pkg::VAL_W-1:0]  o_data
);
    import ils_pkg::*;

    logic signed [VAL_W-1:0] r_data;
    logic                    w_at;
    logic                    w_behind;

    assign w_at     = i_pos == AW'(K);
    assign w_behind = i_pos <= AW'(K);

    always_ff @(posedge i_clk) begin
        if (i_op.ins && w_behind) begin
            r_data <= w_at ? i_value : i_left;
        end else if (i_op.rem && w_behind) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/indexed_list_store.sv
// Ordered list of up to DEPTH signed 32-bit values, held in a row of cells.
// A command beat is taken at a rising edge with i_start high and o_busy low.
// It carries an action (append, insert at index, remove at index, remove
// first, remove last, read), an index and a value. Exactly one result beat
// follows: o_strobe is high for one cycle, the cycle after the command, with
// o_result holding ok, the length after the action and the read value.
// A new command can be taken in every cycle while o_busy is low: an
// insert, or a removal other than remove last, moves every entry behind
// the position by one cell in the same clock; a read selects one cell via a
// multiplexer. Refused actions report ok low with the length unchanged.
// Synchronous reset empties the list; o_busy is high during reset and is
// cleared by the first clock edge after it. The receiver cannot stall, so
// every result beat must be captured in the cycle in which o_strobe is high.
`include "assert_macros.svh"

module indexed_list_store #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ils_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_strobe,
    output ils_pkg::t_result o_result
);
    import ils_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int MW = (CW > IDX_W) ? CW : IDX_W;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_busy;
    logic                    r_strobe;
    t_result                 r_result;

    logic                    w_acc;
    logic                    w_full;
    logic                    w_empty;
    logic [MW-1:0]           w_idx;
    logic [MW-1:0]           w_cnt;
    logic                    w_in_list;
    logic                    w_in_ins;
    logic                    w_ok;
    logic signed [VAL_W-1:0] w_rd;
    t_cell_op                w_op;
    t_cell_op                w_cell_op;
    logic [AW-1:0]           w_pos;
    logic signed [VAL_W-1:0] w_q [DEPTH];

    assign w_acc     = i_start && !r_busy;
    assign w_full    = r_count == CW'(DEPTH);
    assign w_empty   = r_count == '0;
    assign w_idx     = MW'(i_cmd.index);
    assign w_cnt     = MW'(r_count);
    assign w_in_list = w_idx < w_cnt;
    assign w_in_ins  = w_idx <= w_cnt;

    always_comb begin
        w_ok    = 1'b0;
        w_op    = '0;
        w_pos   = '0;
        w_rd    = '0;
        n_count = r_count;
        case (i_cmd.action)
            ACT_APPEND: begin
                if (!w_full) begin
                    w_ok    = 1'b1;
                    w_op.ins = 1'b1;
                    w_pos   = r_count[AW-1:0];
                    n_count = r_count + CW'(1);
                end
            end
            ACT_INSERT: begin
                if (!w_full && w_in_ins) begin
                    w_ok    = 1'b1;
                    w_op.ins = 1'b1;
                    w_pos   = w_idx[AW-1:0];
                    n_count = r_count + CW'(1);
                end
            end
            ACT_REMOVE_AT: begin
                if (w_in_list) begin
                    w_ok    = 1'b1;
                    w_op.rem = 1'b1;
                    w_pos   = w_idx[AW-1:0];
                    n_count = r_count - CW'(1);
                end
            end
            ACT_REMOVE_FIRST: begin
                if (!w_empty) begin
                    w_ok    = 1'b1;
                    w_op.rem = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            ACT_REMOVE_LAST: begin
                if (!w_empty) begin
                    w_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            ACT_READ: begin
                if (w_in_list) begin
                    w_ok = 1'b1;
                    w_rd = w_q[w_idx[AW-1:0]];
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign w_cell_op = w_acc ? w_op : '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = i_cmd.value;
        end else begin : g_mid_left
            assign w_left = w_q[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_right
            assign w_right = w_q[k+1];
        end
        ils_cell #(
            .AW (AW),
            .K  (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_pos   (w_pos),
            .i_value (i_cmd.value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= w_acc;
            if (w_acc) begin
                r_count             <= n_count;
                r_result.ok         <= w_ok;
                r_result.length     <= LEN_W'(n_count);
                r_result.read_value <= w_rd;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `ASSERT_NEXT(a_beat_follows, w_acc, r_strobe, "command beat without result beat")
    `ASSERT_ALWAYS(a_beat_has_cmd, !r_strobe || !$past(i_rst_n) || $past(w_acc),
        "result beat without command beat")
    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "entry count beyond depth")
    `ASSERT_ALWAYS(a_count_moves, !$past(i_rst_n) || r_count == $past(r_count) || $past(w_acc),
        "entry count changed without a command")

endmodule
